@@ design/ping_rtt_and_loss_monitor_assert.svh @@
// assertion macros for the ping monitor
`ifndef PING_RTT_AND_LOSS_MONITOR_ASSERT_SVH
`define PING_RTT_AND_LOSS_MONITOR_ASSERT_SVH

// same-cycle implication
`define PRLM_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication
`define PRLM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

@@ design/prlm_pkg.sv @@
// types, codes and helpers for the ping monitor
`timescale 1ns / 1ps
package prlm_pkg;

   localparam int unsigned TABLE_SLOTS_DEF = 32;

   localparam logic [1:0] CSR_PING_ENABLE = 2'd0;
   localparam logic [1:0] CSR_INTERVAL    = 2'd1;
   localparam logic [1:0] CSR_MAX_LAG     = 2'd2;

   localparam logic MODE_SEND  = 1'b0;
   localparam logic MODE_REPLY = 1'b1;

   localparam logic [2:0] ST_ISSUED       = 3'd0;
   localparam logic [2:0] ST_IGNORED      = 3'd1;
   localparam logic [2:0] ST_OUT_OF_ORDER = 3'd2;
   localparam logic [2:0] ST_DUPLICATE    = 3'd3;
   localparam logic [2:0] ST_EXCESS_LAG   = 3'd4;
   localparam logic [2:0] ST_LAG_ONLY     = 3'd5;
   localparam logic [2:0] ST_FULL         = 3'd6;

   typedef struct packed {
      logic        mode;
      logic [30:0] now_ms;
      logic [30:0] raw_sent_count;
      logic [30:0] raw_recv_count;
      logic [7:0]  reply_number;
      logic        reply_valid_mark;
      logic [30:0] client_recv_count;
      logic [30:0] client_sent_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  issued_number;
      logic [15:0] lag_ms;
      logic [6:0]  total_loss_s2c;
      logic [6:0]  total_loss_c2s;
      logic [6:0]  interval_loss_s2c;
      logic [6:0]  interval_loss_c2s;
      logic [15:0] mean_rtt_ms;
      logic [15:0] stdev_rtt_ms;
      logic [15:0] silent_pings;
   } rsp_type;

   function automatic logic [6:0] clamp_pct(input logic signed [64:0] v);
      logic [6:0] r;
      if (v < 0) r = '0;
      else if (v > 65'sd100) r = 7'd100;
      else r = v[6:0];
      return r;
   endfunction

endpackage

@@ design/ping_rtt_and_loss_monitor.sv @@
// ping round-trip and loss monitor, top level
`timescale 1ns / 1ps
// One word is handled at a time. A send word passes through the slot write and the
// response load. A reply word may stop early (ignored, out of order, duplicate or excess
// lag) or run through a full update, whose length is set by the shared restoring divider,
// which retires one quotient bit per cycle over 64 steps and is used up to seven times per
// reply, plus the 32-step integer root. The probe table is one synchronous memory with
// per-slot valid and answered flags, so no clearing pass follows reset. A result may wait
// in the output register while the next word is taken.
module ping_rtt_and_loss_monitor import prlm_pkg::*; #(
   parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned RECIP  = ((1 << 24) + TABLE_SLOTS - 1) / TABLE_SLOTS;

   typedef enum logic [4:0] {
      S_IDLE, S_SCREEN, S_LAG, S_MEAN, S_VAR0, S_SQRT0, S_SQRT, S_STATS_DONE,
      S_LOSS0, S_LOSS1, S_TL_S2C, S_TL_C2S, S_IL0, S_IL_S2C, S_IL_C2S, S_TIMER,
      S_DIV, S_DIV_END, S_FINISH
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] id);
      logic [32:0] p;
      logic [7:0]  q;
      logic [8:0]  r;
      p = 33'(id) * 33'(RECIP);
      q = p[31:24];
      r = {1'b0, id} - 9'(16'(q) * 16'(TABLE_SLOTS));
      return r[SLOT_W-1:0];
   endfunction

   state_type state_ff, div_ret_ff, div_ret;
   req_type   req_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;

   logic        ping_enable_ff;
   logic [15:0] interval_ff, max_lag_ff;
   logic [7:0]  next_id_ff, last_id_ff, issued_ff;
   logic [2:0]  status_ff;
   logic [15:0] cur_lag_ff, mean_ff, stdev_ff, ghost_ff, m_ff;
   logic [6:0]  tl_s2c_ff, tl_c2s_ff, il_s2c_ff, il_c2s_ff;
   logic [31:0] prev0_ff, prev1_ff, offs0_ff, offs1_ff, timer_ff;
   logic [31:0] base0_ff, base1_ff, base2_ff, base3_ff;
   logic [31:0] count_ff;
   logic [47:0] lag_sum_ff;
   logic [63:0] sq_sum_ff, prod_ff;
   logic        loss_ok_ff;
   logic [30:0] sent_ff;
   logic [31:0] d_ff, c_ff, ru_ff, pr_ff;

   logic [TABLE_SLOTS-1:0] vld_ff, answered_ff;
   logic [SLOT_W-1:0]      idx_ff;
   logic [61:0]            slot_mem [TABLE_SLOTS];
   logic [61:0]            rd_ff;

   // divider and root
   logic [63:0] div_n_ff, div_d_ff, div_rem_ff;
   logic        div_neg_ff;
   logic [5:0]  div_cnt_ff;
   logic signed [64:0] q_ff;
   logic [63:0] sqv_ff, root_ff, rbit_ff;

   logic              div_start;
   logic signed [64:0] div_a, div_b;
   logic [64:0]       div_shift;
   logic              div_ge;
   logic [63:0]       sq_t;
   logic              sq_ge;

   logic              accept, send_acc, mem_we;
   logic [7:0]        next_nx;
   logic [SLOT_W-1:0] send_idx, rep_idx;
   logic [31:0]       sent32;
   logic [7:0]        id_diff;
   logic              ooo;
   logic [30:0]       slot_time, slot_sent;
   logic [31:0]       lag_s;
   logic              lag_bad;
   logic [15:0]       lag16;
   logic [31:0]       lag_sq;
   logic [47:0]       sum_nx;
   logic [63:0]       sq_nx;
   logic [31:0]       count_nx;
   logic [31:0]       recv_corr;
   logic [15:0]       ivl;
   logic signed [32:0] d0, old0;
   logic signed [31:0] c0, old1;
   logic [31:0]       ru0, adj;
   logic [31:0]       ps, pr;
   logic signed [33:0] ddiff, cdiff;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = req_valid && req_ready;
   assign send_acc  = accept && (req_data.mode == MODE_SEND);

   assign next_nx  = next_id_ff + 8'd1;
   assign send_idx = slot_of(next_nx);
   assign rep_idx  = slot_of(req_ff.reply_number);
   assign sent32   = {1'b0, req_data.raw_sent_count} + offs0_ff;
   assign mem_we   = send_acc;

   assign id_diff = req_ff.reply_number - last_id_ff;
   assign ooo = (id_diff > 8'd128) ||
                (id_diff == 8'd128 && req_ff.reply_number < last_id_ff);

   assign slot_time = vld_ff[idx_ff] ? rd_ff[61:31] : '0;
   assign slot_sent = vld_ff[idx_ff] ? rd_ff[30:0] : '0;
   assign lag_s     = {1'b0, req_ff.now_ms} - {1'b0, slot_time};
   assign lag_bad   = lag_s[31] || (lag_s[30:0] > 31'(max_lag_ff));
   assign lag16     = lag_s[15:0];
   assign lag_sq    = 32'(lag16) * 32'(lag16);
   assign sum_nx    = lag_sum_ff + 48'(lag16);
   assign sq_nx     = sq_sum_ff + 64'(lag_sq);
   assign count_nx  = count_ff + 32'd1;
   assign recv_corr = {1'b0, req_ff.raw_recv_count} + offs1_ff;

   assign ivl  = (interval_ff == '0) ? 16'd1 : interval_ff;
   assign d0   = $signed({2'b0, sent_ff}) - $signed({2'b0, req_ff.client_recv_count});
   assign old0 = 33'($signed(prev0_ff));
   assign ru0  = recv_corr;
   assign c0   = $signed({1'b0, req_ff.client_sent_count} - ru0);
   assign old1 = $signed(prev1_ff);
   assign adj  = 32'(old1 - c0);

   assign ps    = {1'b0, sent_ff} - base0_ff;
   assign pr    = ru_ff - base1_ff;
   assign ddiff = 34'($signed(ps)) - 34'($signed(d_ff - base2_ff));
   assign cdiff = 34'($signed(pr_ff)) - 34'($signed(c_ff - base3_ff));

   assign div_shift = {div_rem_ff, div_n_ff[63]};
   assign div_ge    = div_shift >= {1'b0, div_d_ff};
   assign sq_t      = root_ff + rbit_ff;
   assign sq_ge     = sqv_ff >= sq_t;

   always_comb begin
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      div_ret   = S_IDLE;
      unique case (state_ff)
         S_LAG: begin
            if (!lag_bad && count_ff != '1 && count_ff != '0) begin
               div_start = 1'b1;
               div_a     = 65'(sum_nx);
               div_b     = 65'(count_nx);
               div_ret   = S_MEAN;
            end
         end
         S_VAR0: begin
            if (sq_sum_ff >= prod_ff) begin
               div_start = 1'b1;
               div_a     = 65'(sq_sum_ff - prod_ff);
               div_b     = 65'(count_ff - 32'd1);
               div_ret   = S_SQRT0;
            end
         end
         S_LOSS1: begin
            div_start = 1'b1;
            div_a     = 65'($signed(d_ff)) * 65'sd200 + 65'(sent_ff);
            div_b     = 65'(sent_ff) << 1;
            div_ret   = S_TL_S2C;
         end
         S_TL_S2C: begin
            if (!ru_ff[31] && ru_ff != '0) begin
               div_start = 1'b1;
               div_a     = 65'($signed(c_ff)) * 65'sd200 + 65'(ru_ff);
               div_b     = 65'(ru_ff) << 1;
               div_ret   = S_TL_C2S;
            end
         end
         S_IL0: begin
            if (ps != '0 && pr != '0) begin
               div_start = 1'b1;
               div_a     = 65'(ddiff) * 65'sd100;
               div_b     = 65'($signed(ps));
               div_ret   = S_IL_S2C;
            end
         end
         S_IL_S2C: begin
            div_start = 1'b1;
            div_a     = 65'(cdiff) * 65'sd100;
            div_b     = 65'($signed(pr_ff));
            div_ret   = S_IL_C2S;
         end
         S_IL_C2S: begin
            div_start = 1'b1;
            div_a     = 65'(timer_ff);
            div_b     = 65'(ivl);
            div_ret   = S_TIMER;
         end
         default: ;
      endcase
   end

   // probe table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[send_idx] <= {req_data.now_ms, sent32[30:0]};
      end
      if (state_ff == S_SCREEN) begin
         rd_ff <= slot_mem[rep_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         div_ret_ff     <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         ping_enable_ff <= 1'b1;
         interval_ff    <= 16'd10;
         max_lag_ff     <= 16'd10000;
         next_id_ff     <= '0;
         last_id_ff     <= '0;
         cur_lag_ff     <= '0;
         mean_ff        <= '0;
         stdev_ff       <= '0;
         ghost_ff       <= '0;
         tl_s2c_ff      <= '0;
         tl_c2s_ff      <= '0;
         il_s2c_ff      <= '0;
         il_c2s_ff      <= '0;
         prev0_ff       <= '0;
         prev1_ff       <= '0;
         offs0_ff       <= '0;
         offs1_ff       <= '0;
         timer_ff       <= '0;
         base0_ff       <= '0;
         base1_ff       <= '0;
         base2_ff       <= '0;
         base3_ff       <= '0;
         count_ff       <= '0;
         lag_sum_ff     <= '0;
         sq_sum_ff      <= '0;
         vld_ff         <= '0;
         answered_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PING_ENABLE: ping_enable_ff <= csr_data[0];
               CSR_INTERVAL:    interval_ff    <= csr_data;
               CSR_MAX_LAG:     max_lag_ff     <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_start) begin
            div_n_ff   <= div_a[64] ? 64'(-div_a) : div_a[63:0];
            div_d_ff   <= div_b[64] ? 64'(-div_b) : div_b[63:0];
            div_neg_ff <= div_a[64] ^ div_b[64];
            div_rem_ff <= '0;
            div_cnt_ff <= '0;
            div_ret_ff <= div_ret;
            state_ff   <= S_DIV;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  if (req_data.mode == MODE_SEND) begin
                     if (ghost_ff != '1) ghost_ff <= ghost_ff + 16'd1;
                     next_id_ff            <= next_nx;
                     vld_ff[send_idx]      <= 1'b1;
                     answered_ff[send_idx] <= 1'b0;
                     status_ff             <= ST_ISSUED;
                     issued_ff             <= next_nx;
                     state_ff              <= S_FINISH;
                  end else begin
                     issued_ff <= '0;
                     state_ff  <= S_SCREEN;
                  end
               end
            end
            S_SCREEN: begin
               priority if (!ping_enable_ff || !req_ff.reply_valid_mark) begin
                  status_ff <= ST_IGNORED;
                  state_ff  <= S_FINISH;
               end else if (ooo) begin
                  ghost_ff  <= '0;
                  status_ff <= ST_OUT_OF_ORDER;
                  state_ff  <= S_FINISH;
               end else if (answered_ff[rep_idx]) begin
                  ghost_ff  <= '0;
                  status_ff <= ST_DUPLICATE;
                  state_ff  <= S_FINISH;
               end else begin
                  ghost_ff             <= '0;
                  last_id_ff           <= req_ff.reply_number;
                  answered_ff[rep_idx] <= 1'b1;
                  idx_ff               <= rep_idx;
                  state_ff             <= S_LAG;
               end
            end
            S_LAG: begin
               if (lag_bad) begin
                  cur_lag_ff <= mean_ff;
                  status_ff  <= ST_EXCESS_LAG;
                  state_ff   <= S_FINISH;
               end else begin
                  cur_lag_ff <= lag16;
                  sent_ff    <= slot_sent;
                  loss_ok_ff <= (recv_corr != '0) && (slot_sent != '0);
                  if (count_ff == '1) begin
                     count_ff   <= 32'd1;
                     lag_sum_ff <= '0;
                     sq_sum_ff  <= '0;
                     state_ff   <= S_STATS_DONE;
                  end else begin
                     count_ff   <= count_nx;
                     lag_sum_ff <= sum_nx;
                     sq_sum_ff  <= sq_nx;
                     if (count_ff == '0) state_ff <= S_STATS_DONE;
                  end
               end
            end
            S_MEAN: begin
               m_ff     <= q_ff[15:0];
               prod_ff  <= 64'(q_ff[15:0]) * 64'(lag_sum_ff);
               state_ff <= S_VAR0;
            end
            S_VAR0: begin
               if (sq_sum_ff < prod_ff) begin
                  count_ff   <= 32'd1;
                  lag_sum_ff <= '0;
                  sq_sum_ff  <= '0;
                  state_ff   <= S_STATS_DONE;
               end
            end
            S_SQRT0: begin
               sqv_ff   <= q_ff[63:0];
               root_ff  <= '0;
               rbit_ff  <= 64'd1 << 62;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (sq_ge) begin
                  sqv_ff  <= sqv_ff - sq_t;
                  root_ff <= (root_ff >> 1) + rbit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               rbit_ff <= rbit_ff >> 2;
               if (rbit_ff[0]) begin
                  state_ff <= S_STATS_DONE;
               end
            end
            S_STATS_DONE: begin
               if (div_ret_ff == S_SQRT0) begin
                  mean_ff  <= m_ff;
                  stdev_ff <= (root_ff > 64'hFFFF) ? 16'hFFFF : root_ff[15:0];
               end
               rbit_ff    <= '0;
               div_ret_ff <= S_IDLE;
               if (loss_ok_ff) begin
                  state_ff <= S_LOSS0;
               end else begin
                  status_ff <= ST_LAG_ONLY;
                  state_ff  <= S_FINISH;
               end
            end
            S_LOSS0: begin
               if (timer_ff == '0) timer_ff <= 32'(ivl);
               if (d0 < old0) begin
                  offs0_ff <= offs0_ff + 32'(old0 - d0);
                  d_ff     <= prev0_ff;
               end else begin
                  d_ff     <= d0[31:0];
                  prev0_ff <= d0[31:0];
               end
               if (c0 < old1) begin
                  offs1_ff <= offs1_ff - adj;
                  ru_ff    <= ru0 - adj;
                  c_ff     <= prev1_ff;
               end else begin
                  ru_ff    <= ru0;
                  c_ff     <= c0;
                  prev1_ff <= c0;
               end
               status_ff <= ST_FULL;
               state_ff  <= S_LOSS1;
            end
            S_LOSS1: ;
            S_TL_S2C: begin
               tl_s2c_ff <= clamp_pct(q_ff);
               if (ru_ff[31] || ru_ff == '0) begin
                  tl_c2s_ff <= '0;
                  state_ff  <= S_IL0;
               end
            end
            S_TL_C2S: begin
               tl_c2s_ff <= clamp_pct(q_ff);
               state_ff  <= S_IL0;
            end
            S_IL0: begin
               pr_ff <= pr;
               if (ps == '0 || pr == '0) state_ff <= S_FINISH;
            end
            S_IL_S2C: begin
               il_s2c_ff <= clamp_pct(65'sd100 - q_ff);
            end
            S_IL_C2S: begin
               il_c2s_ff <= clamp_pct(65'sd100 - q_ff);
            end
            S_TIMER: begin
               if (div_rem_ff == '0) begin
                  base0_ff <= {1'b0, sent_ff};
                  base1_ff <= ru_ff;
                  base2_ff <= d_ff;
                  base3_ff <= c_ff;
               end
               timer_ff <= timer_ff + 32'd1;
               state_ff <= S_FINISH;
            end
            S_DIV: begin
               div_rem_ff <= div_ge ? 64'(div_shift - {1'b0, div_d_ff}) : div_shift[63:0];
               div_n_ff   <= {div_n_ff[62:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == '1) state_ff <= S_DIV_END;
            end
            S_DIV_END: begin
               q_ff     <= div_neg_ff ? -$signed({1'b0, div_n_ff}) : $signed({1'b0, div_n_ff});
               state_ff <= div_ret_ff;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff <= '{
                     status:            status_ff,
                     issued_number:     issued_ff,
                     lag_ms:            cur_lag_ff,
                     total_loss_s2c:    tl_s2c_ff,
                     total_loss_c2s:    tl_c2s_ff,
                     interval_loss_s2c: il_s2c_ff,
                     interval_loss_c2s: il_c2s_ff,
                     mean_rtt_ms:       mean_ff,
                     stdev_rtt_ms:      stdev_ff,
                     silent_pings:      ghost_ff
                  };
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`include "ping_rtt_and_loss_monitor_assert.svh"

   `PRLM_ASSERT_NOW(a_div_nonzero, state_ff == S_DIV, div_d_ff != '0)
   `PRLM_ASSERT_NOW(a_lag_marked, state_ff == S_LAG, answered_ff[idx_ff])
   `PRLM_ASSERT_NEXT(a_finish_loads, state_ff == S_FINISH && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE)

endmodule

@@ tb/tb_ping_rtt_and_loss_monitor.sv @@
// testbench for the ping monitor: scoreboard with its own rtt and loss tracker, random traffic
`timescale 1ns / 1ps
module tb_ping_rtt_and_loss_monitor;
   import prlm_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;

   class rtt_loss_tracker;
      bit [31:0] ping_on, interval_regs, lag_limit;
      bit [31:0] slot_time[TABLE_SLOTS_DEF];
      bit [31:0] slot_sent[TABLE_SLOTS_DEF];
      bit slot_answered[TABLE_SLOTS_DEF];
      bit [7:0] next_id, last_reply_id;
      bit [31:0] cur_lag, reply_timer, samples, silent;
      bit [31:0] prev_drop[2];
      bit [31:0] base_mark[4];
      bit [31:0] offsets[2];
      bit [31:0] held[6];
      longint unsigned lag_sum, square_sum;
      rsp_type expected_results[$];
      int fails;

      function new();
         ping_on = 1;
         interval_regs = 10;
         lag_limit = 10000;
         fails = 0;
      endfunction

      function longint u64(bit [31:0] v);
         return {32'b0, v};
      endfunction

      function longint s32(bit [31:0] v);
         return {{32{v[31]}}, v};
      endfunction

      function bit [31:0] pct(longint v);
         if (v < 0) return 0;
         if (v > 100) return 100;
         return 32'(v);
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_PING_ENABLE: ping_on = 32'(val[0]);
            CSR_INTERVAL:    interval_regs = 32'(val);
            CSR_MAX_LAG:     lag_limit = 32'(val);
            default: ;
         endcase
      endfunction

      function void add_lag_sample(bit [31:0] lag);
         longint unsigned m, prod, var_q, sd;
         if (samples == 32'hFFFF_FFFF) begin
            samples = 1;
            lag_sum = 0;
            square_sum = 0;
            return;
         end
         samples++;
         lag_sum += lag;
         square_sum += u64(lag) * u64(lag);
         if (samples == 1) return;
         m = lag_sum / samples;
         prod = m * lag_sum;
         if (square_sum < prod) begin
            samples = 1;
            lag_sum = 0;
            square_sum = 0;
            return;
         end
         var_q = (square_sum - prod) / (samples - 1);
         sd = int_root(var_q);
         held[0] = (m > 65535) ? 65535 : 32'(m);
         held[1] = (sd > 65535) ? 65535 : 32'(sd);
      endfunction

      function void update_loss(bit [31:0] s_at, bit [31:0] recv_c, bit [31:0] sent_c,
                                bit [31:0] r_raw);
         bit [31:0] ivl, r_u, adj;
         longint d, c, old, r, ps, pr, num;
         ivl = (interval_regs == 0) ? 1 : interval_regs;
         r_u = r_raw + offsets[1];
         if (reply_timer == 0) reply_timer = ivl;
         d = u64(s_at) - u64(recv_c);
         old = s32(prev_drop[0]);
         if (d < old) begin
            offsets[0] += 32'(old - d);
            d = old;
         end
         held[2] = pct((200 * d + u64(s_at)) / (2 * u64(s_at)));
         c = s32(sent_c - r_u);
         old = s32(prev_drop[1]);
         if (c < old) begin
            adj = 32'(old - c);
            offsets[1] -= adj;
            r_u -= adj;
            c = old;
         end
         r = s32(r_u);
         held[3] = (r <= 0) ? 0 : pct((200 * c + r) / (2 * r));
         prev_drop[0] = 32'(d);
         prev_drop[1] = 32'(c);
         ps = s32(s_at - base_mark[0]);
         pr = s32(r_u - base_mark[1]);
         if (ps == 0 || pr == 0) return;
         num = 100 * (ps - s32(32'(d) - base_mark[2]));
         held[4] = pct(100 - num / ps);
         num = 100 * (pr - s32(32'(c) - base_mark[3]));
         held[5] = pct(100 - num / pr);
         if (reply_timer % ivl == 0) begin
            base_mark[2] = 32'(d);
            base_mark[3] = 32'(c);
            base_mark[0] = s_at;
            base_mark[1] = r_u;
         end
         reply_timer++;
      endfunction

      function logic [2:0] screen_reply(req_type w);
         int diff, idx;
         longint lag;
         bit [31:0] rsum;
         if (ping_on == 0 || w.reply_valid_mark !== 1'b1) return ST_IGNORED;
         silent = 0;
         diff = int'(w.reply_number) - int'(last_reply_id);
         if (diff > 128) diff -= 256;
         else if (diff < -128) diff += 256;
         if (diff < 0) return ST_OUT_OF_ORDER;
         idx = w.reply_number % TABLE_SLOTS_DEF;
         if (slot_answered[idx]) return ST_DUPLICATE;
         last_reply_id = w.reply_number;
         slot_answered[idx] = 1;
         lag = u64({1'b0, w.now_ms}) - u64(slot_time[idx]);
         if (lag > u64(lag_limit) || lag < 0) begin
            cur_lag = held[0];
            return ST_EXCESS_LAG;
         end
         cur_lag = 32'(lag) & 32'hFFFF;
         add_lag_sample(cur_lag);
         rsum = {1'b0, w.raw_recv_count} + offsets[1];
         if (rsum == 0 || slot_sent[idx] == 0) return ST_LAG_ONLY;
         update_loss(slot_sent[idx], {1'b0, w.client_recv_count},
                     {1'b0, w.client_sent_count}, {1'b0, w.raw_recv_count});
         return ST_FULL;
      endfunction

      function void note_word(req_type w);
         rsp_type o;
         int idx;
         o = '0;
         if (w.mode == MODE_SEND) begin
            if (silent < 32'hFFFF) silent++;
            next_id = next_id + 8'd1;
            idx = next_id % TABLE_SLOTS_DEF;
            slot_time[idx] = {1'b0, w.now_ms};
            slot_sent[idx] = ({1'b0, w.raw_sent_count} + offsets[0]) & 32'h7FFF_FFFF;
            slot_answered[idx] = 0;
            o.status = ST_ISSUED;
            o.issued_number = next_id;
         end else begin
            o.status = screen_reply(w);
         end
         o.lag_ms = cur_lag[15:0];
         o.total_loss_s2c = held[2][6:0];
         o.total_loss_c2s = held[3][6:0];
         o.interval_loss_s2c = held[4][6:0];
         o.interval_loss_c2s = held[5][6:0];
         o.mean_rtt_ms = held[0][15:0];
         o.stdev_rtt_ms = held[1][15:0];
         o.silent_pings = silent[15:0];
         expected_results.push_back(o);
      endfunction

      function void cmp(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            $error("%s expected %0d actual %0d", name, e, a);
            fails++;
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected");
            fails++;
            return;
         end
         e = expected_results.pop_front();
         cmp("status", e.status, a.status);
         cmp("issued_number", e.issued_number, a.issued_number);
         cmp("lag_ms", e.lag_ms, a.lag_ms);
         cmp("total_loss_s2c", e.total_loss_s2c, a.total_loss_s2c);
         cmp("total_loss_c2s", e.total_loss_c2s, a.total_loss_c2s);
         cmp("interval_loss_s2c", e.interval_loss_s2c, a.interval_loss_s2c);
         cmp("interval_loss_c2s", e.interval_loss_c2s, a.interval_loss_c2s);
         cmp("mean_rtt_ms", e.mean_rtt_ms, a.mean_rtt_ms);
         cmp("stdev_rtt_ms", e.stdev_rtt_ms, a.stdev_rtt_ms);
         cmp("silent_pings", e.silent_pings, a.silent_pings);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   rtt_loss_tracker tracker = new();
   int cycles = 0;
   int results_seen = 0;
   int stall_left = 0;
   bit big_stall_done = 0;
   bit quiet = 0;

   bit [30:0] clk_ms, srv_sent, srv_recv;
   bit [7:0] issued_ids;

   ping_rtt_and_loss_monitor u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL ping_rtt_and_loss_monitor");
         $finish;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result(rsp_data);
         results_seen++;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!big_stall_done && results_seen >= 200) begin
         big_stall_done = 1;
         stall_left = 4000;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
      end
   end

   task automatic send_word(req_type w);
      int gap;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(w);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function req_type mk(logic m, logic [30:0] t, logic [30:0] s, logic [30:0] r,
                        logic [7:0] n, logic k, logic [30:0] cr, logic [30:0] cs);
      req_type w;
      w.mode = m;
      w.now_ms = t;
      w.raw_sent_count = s;
      w.raw_recv_count = r;
      w.reply_number = n;
      w.reply_valid_mark = k;
      w.client_recv_count = cr;
      w.client_sent_count = cs;
      return w;
   endfunction

   function req_type noise_word();
      return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
   endfunction

   // mostly well-formed ping/reply traffic with growing counters
   function req_type traffic_word();
      bit [7:0] n;
      if ($urandom_range(0, 9) == 0) return noise_word();
      if ($urandom_range(0, 1) == 0) begin
         clk_ms += $urandom_range(1, 50);
         srv_sent += $urandom_range(1, 20);
         issued_ids++;
         return mk(MODE_SEND, clk_ms, srv_sent, srv_recv, $urandom, $urandom,
                   $urandom, $urandom);
      end
      n = issued_ids - 8'($urandom_range(0, 3));
      clk_ms += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 70000)
                                             : $urandom_range(0, 300);
      srv_recv += $urandom_range(0, 20);
      return mk(MODE_REPLY, clk_ms, srv_sent, srv_recv, n,
                $urandom_range(0, 19) != 0,
                srv_sent - 31'($urandom_range(0, 6)),
                srv_recv + 31'($urandom_range(0, 6)));
   endfunction

   initial begin
      bit [15:0] en_set[6] = '{1, 1, 0, 1, 1, 1};
      bit [15:0] ivl_set[6] = '{10, 1, 3, 0, 65535, 4};
      bit [15:0] lag_set[6] = '{10000, 65535, 100, 0, 500, 10000};
      int counts[6] = '{160, 160, 30, 120, 180, 180};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings
      send_word(mk(MODE_SEND, 100, 0, 0, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 150, 0, 5, 1, 1, 0, 0));
      send_word(mk(MODE_REPLY, 160, 0, 5, 1, 1, 0, 0));
      send_word(mk(MODE_REPLY, 170, 0, 5, 0, 1, 0, 0));
      send_word(mk(MODE_REPLY, 170, 0, 5, 1, 0, 0, 0));
      send_word(mk(MODE_SEND, 1000, 50, 30, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 1020, 50, 40, 2, 1, 45, 42));
      send_word(mk(MODE_SEND, 2000, 100, 50, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 22000, 100, 60, 3, 1, 90, 58));
      send_word(mk(MODE_SEND, '1, '1, '1, '1, '1, '1, '1));
      send_word(mk(MODE_REPLY, '1, '1, '1, 4, 1, 0, '1));
      send_word(mk(MODE_SEND, 0, 200, 0, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 0, 200, 0, 5, 1, 190, 0));
      send_word(mk(MODE_REPLY, 10, 0, 0, 200, 1, 0, 0));
      send_word(mk(MODE_REPLY, 3000, 0, 0, 40, 1, 0, 0));
      send_word(mk(MODE_SEND, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 9000, 300, 200, 41, 1, 250, 260));
      send_word(mk(MODE_SEND, 9500, 400, 210, 0, 0, 0, 0));
      send_word(mk(MODE_REPLY, 9600, 400, 220, 42, 1, 500, 100));
      drain();

      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_PING_ENABLE, en_set[p]);
         write_csr(CSR_INTERVAL, ivl_set[p]);
         write_csr(CSR_MAX_LAG, lag_set[p]);
         quiet = (p % 2 == 1);
         clk_ms = $urandom;
         srv_sent = $urandom_range(0, 1000);
         srv_recv = $urandom_range(0, 1000);
         issued_ids = tracker.next_id;
         for (int k = 0; k < counts[p]; k++) send_word(traffic_word());
         drain();
      end

      quiet = 0;
      repeat (600) @(posedge clock);
      if (tracker.fails == 0 && tracker.expected_results.size() == 0) begin
         $display("PASS ping_rtt_and_loss_monitor");
      end else begin
         $display("FAIL ping_rtt_and_loss_monitor");
      end
      $finish;
   end
endmodule
